// File: hw/rtl/iss_pkg.sv
package iss_pkg;

    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 16;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef enum logic {
        OP_PATTERN,
        OP_ELEMENT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_qitem;

endpackage

// File: hw/rtl/iss_in_if.sv
interface iss_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [iss_pkg::SLOT_W-1:0]          pattern_slot;
    logic signed [iss_pkg::WORD_W-1:0]   word_value;
    logic                                last_element;

    modport source (
        output valid, command, pattern_slot, word_value, last_element,
        input  ready
    );
    modport sink (
        input  valid, command, pattern_slot, word_value, last_element,
        output ready
    );
endinterface

// File: hw/rtl/iss_out_if.sv
interface iss_out_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [iss_pkg::IDX_W-1:0]        match_index;

    modport source (
        output valid, found, match_index,
        input  ready
    );
    modport sink (
        input  valid, found, match_index,
        output ready
    );
endinterface

// File: hw/rtl/iss_front.sv
module iss_front #(
    parameter int PATTERN_MAX = 16
) (
    iss_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output iss_pkg::t_qitem o_item
);
    import iss_pkg::*;

    logic w_accept;
    logic w_drop;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    // A pattern beat aimed past the end of the store has no effect and is dropped here.
    assign w_drop = !i_in.command &&
                    ((SLOT_W + 8)'(i_in.pattern_slot) >= (SLOT_W + 8)'(PATTERN_MAX));

    assign o_push = w_accept && !w_drop;

    always_comb begin
        o_item.op   = i_in.command ? OP_ELEMENT : OP_PATTERN;
        o_item.slot = i_in.pattern_slot;
        o_item.word = i_in.word_value;
        o_item.last = i_in.command && i_in.last_element;
    end

endmodule

// File: hw/rtl/iss_queue.sv
module iss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iss_pkg::t_qitem i_item,
    output logic            o_full,
    output logic            o_valid,
    output iss_pkg::t_qitem o_head,
    input  logic            i_pop
);
    import iss_pkg::*;

    t_qitem              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic [QPTR_W-1:0]   n_wp;
    logic [QPTR_W-1:0]   n_rp;
    logic [QPTR_W:0]     n_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: hw/rtl/iss_back.sv
module iss_back #(
    parameter int PATTERN_MAX  = 16,
    parameter int MAX_ELEMENTS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iss_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    input  iss_pkg::t_qitem             i_head,
    output logic                        o_pop,
    iss_out_if.source                   o_res
);
    import iss_pkg::*;

    localparam int LEN_PM  = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W   = (LEN_PM > CFG_W) ? LEN_PM : CFG_W;
    localparam int LW      = CMP_W + 1;
    localparam int SLOT_IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W   = ((POS_W > LW) ? POS_W : LW) + 1;

    logic [WORD_W-1:0] r_pat [PATTERN_MAX];
    logic [WORD_W-1:0] r_win [PATTERN_MAX];
    logic [WORD_W-1:0] w_win_next [PATTERN_MAX];
    logic [CFG_W-1:0]  r_cfg;
    logic [POS_W-1:0]  r_pos;
    logic              r_seen;
    logic [IDX_W-1:0]  r_start;
    logic              r_oval;
    logic              r_found;
    logic [IDX_W-1:0]  r_idx;

    logic [LW-1:0]          w_len;
    logic [PATTERN_MAX-1:0] w_hit;
    logic                   w_match;
    logic                   w_pos_ok;
    logic [SUM_W-1:0]       w_pos1;
    logic [SUM_W-1:0]       w_start;
    logic                   w_fit;
    logic                   n_seen;
    logic [IDX_W-1:0]       n_start;
    logic                   w_elem;
    logic                   w_pat;
    logic                   w_out_busy;

    assign w_out_busy = r_oval && !o_res.ready;
    assign o_pop      = i_valid && !(i_head.op == OP_ELEMENT && i_head.last && w_out_busy);
    assign w_elem     = o_pop && (i_head.op == OP_ELEMENT);
    assign w_pat      = o_pop && (i_head.op == OP_PATTERN);

    assign w_len = (LW'(r_cfg) > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(r_cfg);

    always_comb begin
        w_win_next[0] = i_head.word;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            w_win_next[i] = r_win[i-1];
        end
    end

    // Window entry j, counted from the newest beat, lines up with pattern word len-1-j.
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            w_hit[j] = 1'b1;
            if (LW'(j) < w_len) begin
                w_hit[j] = (w_win_next[j] == r_pat[SLOT_IW'(w_len - LW'(j) - LW'(1))]);
            end
        end
    end

    assign w_match  = &w_hit;
    assign w_pos_ok = (r_pos < POS_W'(MAX_ELEMENTS));
    assign w_pos1   = SUM_W'(r_pos) + SUM_W'(1);
    assign w_fit    = (w_pos1 >= SUM_W'(w_len));
    assign w_start  = w_pos1 - SUM_W'(w_len);

    always_comb begin
        n_seen  = r_seen;
        n_start = r_start;
        if (!r_seen && w_pos_ok) begin
            if (w_len == '0) begin
                n_seen  = 1'b1;
                n_start = '0;
            end else if (w_fit && w_match) begin
                n_seen  = 1'b1;
                n_start = IDX_W'(w_start);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
            r_oval  <= 1'b0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (w_elem && i_head.last) begin
                r_oval  <= 1'b1;
                r_pos   <= '0;
                r_seen  <= 1'b0;
                r_start <= '0;
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                if (o_res.ready) begin
                    r_oval <= 1'b0;
                end
                if (w_elem) begin
                    r_win   <= w_win_next;
                    r_pos   <= w_pos_ok ? r_pos + POS_W'(1) : r_pos;
                    r_seen  <= n_seen;
                    r_start <= n_start;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_elem && i_head.last) begin
            r_found <= n_seen;
            r_idx   <= n_seen ? n_start : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pat) begin
            r_pat[SLOT_IW'(i_head.slot)] <= i_head.word;
        end
    end

    assign o_res.valid       = r_oval;
    assign o_res.found       = r_found;
    assign o_res.match_index = r_idx;

endmodule

// File: hw/rtl/integer_subsequence_search.sv
// Streams 32-bit words and reports where a stored pattern first occurs. A beat with
// command 0 loads one pattern word into the slot it names; a beat with command 1 is
// one array element, and the element marked last returns one result with the found
// flag and the start index, then clears the search so the next array starts at index
// zero. The pattern store and the length register keep their contents across searches,
// and no pattern slot may be read before it has been written. The block takes one beat
// every cycle unless a last element waits on a pending result. The front side checks
// and queues each beat, and the back side shifts the element into its window and
// compares all pattern words in parallel, combinationally. A last element passes
// through the queue and its result waits in an output register; the input flows on
// meanwhile, and only a further last element stalls until the pending result is taken.
module integer_subsequence_search #(
    parameter int PATTERN_MAX  = 16,
    parameter int MAX_ELEMENTS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iss_pkg::CFG_W-1:0]   i_cfg_data,
    iss_in_if.sink                      i_in,
    iss_out_if.source                   o_res
);
    import iss_pkg::*;

    logic   w_push;
    t_qitem w_item;
    logic   w_qfull;
    logic   w_qvalid;
    t_qitem w_head;
    logic   w_pop;

    iss_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_in   (i_in),
        .i_full (w_qfull),
        .o_push (w_push),
        .o_item (w_item)
    );

    iss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_qfull),
        .o_valid (w_qvalid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    iss_back #(
        .PATTERN_MAX  (PATTERN_MAX),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_qvalid),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qfull)
        else $error("Queue written while full.");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("Queue read while empty.");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.op == OP_ELEMENT && w_head.last) |=> o_res.valid)
        else $error("Last element taken without a result.");
`endif

endmodule
